// ===== design/polygon_most_orthogonal_edge_select_macros.svh =====
// assertion macros for the polygon most-orthogonal edge selector
// used by the top level only, no other dependencies
`ifndef POLYGON_MOST_ORTHOGONAL_EDGE_SELECT_MACROS_SVH
`define POLYGON_MOST_ORTHOGONAL_EDGE_SELECT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PMOES_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pmoes assertion failed");

// antecedent implies consequent in the following cycle
`define PMOES_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pmoes assertion failed");

`endif

// ===== design/pmoes_pkg.sv =====
// shared types and constants for the polygon most-orthogonal edge selector
// no dependencies
package pmoes_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int COORD_W      = 14;
  localparam int REF_W        = 15;
  localparam int DIFF_W       = 15;
  localparam int EDGE_W       = 8;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int SQSUM_W      = PROD_W + 1;
  localparam int DOT_W        = PROD_W + 2;
  localparam int METRIC_W     = 2 * SQSUM_W;
  localparam int CFG_IDX_W    = 2;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF_X = 2'd0,
    CFG_REF_Y = 2'd1,
    CFG_REF_Z = 2'd2,
    CFG_REF_W = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    F_RUN,
    F_CLOSE
  } front_state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] w;
  } vertex_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] ex;
    logic signed [DIFF_W-1:0] ey;
    logic signed [DIFF_W-1:0] ez;
    logic signed [DIFF_W-1:0] ew;
    logic [EDGE_W-1:0]        idx;
    logic                     close;
    logic                     ovf;
  } edge_job_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_wr_t;

  function automatic logic signed [DIFF_W-1:0] coord_diff(
    input logic signed [COORD_W-1:0] b,
    input logic signed [COORD_W-1:0] a
  );
    coord_diff = DIFF_W'(b) - DIFF_W'(a);
  endfunction

endpackage

// ===== design/pmoes_front.sv =====
// front end: accepts vertices, tracks polygon state and issues edge jobs
// depends on pmoes_pkg
module pmoes_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pmoes_pkg::vertex_t                  vtx,
  input  logic                                last_vertex,
  output pmoes_pkg::q_wr_t                    qw_ctl,
  input  logic                                q_full,
  output pmoes_pkg::edge_job_t                job
);

  localparam logic [pmoes_pkg::CNT_W-1:0] MAX_CNT =
    pmoes_pkg::CNT_W'(pmoes_pkg::MAX_VERTICES);

  pmoes_pkg::front_state_t state, state_next;
  logic [pmoes_pkg::CNT_W-1:0] vertex_count;
  logic                        count_overflowed;
  pmoes_pkg::vertex_t          first_vertex;
  pmoes_pkg::vertex_t          previous_vertex;
  logic                        accept;
  logic [pmoes_pkg::EDGE_W-1:0] cur_idx;

  assign accept  = in_valid && !in_stall;
  assign cur_idx = pmoes_pkg::EDGE_W'(vertex_count - 1'b1);

  always_comb begin
    state_next = state;
    unique case (state)
      pmoes_pkg::F_RUN: begin
        if (accept && last_vertex && vertex_count != '0 && vertex_count != MAX_CNT) begin
          state_next = pmoes_pkg::F_CLOSE;
        end
      end
      pmoes_pkg::F_CLOSE: begin
        if (!q_full) begin
          state_next = pmoes_pkg::F_RUN;
        end
      end
      default: state_next = pmoes_pkg::F_RUN;
    endcase
  end

  always_comb begin
    in_stall      = 1'b0;
    qw_ctl.push   = 1'b0;
    qw_ctl.full   = q_full;
    job.ex        = pmoes_pkg::coord_diff(first_vertex.x, previous_vertex.x);
    job.ey        = pmoes_pkg::coord_diff(first_vertex.y, previous_vertex.y);
    job.ez        = pmoes_pkg::coord_diff(first_vertex.z, previous_vertex.z);
    job.ew        = pmoes_pkg::coord_diff(first_vertex.w, previous_vertex.w);
    job.idx       = cur_idx;
    job.close     = 1'b1;
    job.ovf       = count_overflowed;
    unique case (state)
      pmoes_pkg::F_RUN: begin
        in_stall = q_full;
        if (accept) begin
          priority if (vertex_count == MAX_CNT) begin
            qw_ctl.push = last_vertex;
            job.ovf     = 1'b1;
          end else if (vertex_count == '0) begin
            // single vertex polygon closes on a zero edge
            qw_ctl.push = last_vertex;
            job.ex      = '0;
            job.ey      = '0;
            job.ez      = '0;
            job.ew      = '0;
            job.idx     = '0;
          end else begin
            qw_ctl.push = 1'b1;
            job.ex      = pmoes_pkg::coord_diff(vtx.x, previous_vertex.x);
            job.ey      = pmoes_pkg::coord_diff(vtx.y, previous_vertex.y);
            job.ez      = pmoes_pkg::coord_diff(vtx.z, previous_vertex.z);
            job.ew      = pmoes_pkg::coord_diff(vtx.w, previous_vertex.w);
            job.close   = 1'b0;
          end
        end
      end
      pmoes_pkg::F_CLOSE: begin
        in_stall    = 1'b1;
        qw_ctl.push = !q_full;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= pmoes_pkg::F_RUN;
      vertex_count     <= '0;
      count_overflowed <= 1'b0;
    end else begin
      state <= state_next;
      if (state == pmoes_pkg::F_CLOSE) begin
        if (!q_full) begin
          vertex_count     <= '0;
          count_overflowed <= 1'b0;
        end
      end else if (accept) begin
        if (vertex_count == MAX_CNT) begin
          count_overflowed <= 1'b1;
        end else begin
          vertex_count <= vertex_count + 1'b1;
        end
        if (last_vertex && (vertex_count == '0 || vertex_count == MAX_CNT)) begin
          vertex_count     <= '0;
          count_overflowed <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == pmoes_pkg::F_RUN && accept && vertex_count != MAX_CNT) begin
      previous_vertex <= vtx;
      if (vertex_count == '0) begin
        first_vertex <= vtx;
      end
    end
  end

endmodule

// ===== design/pmoes_queue.sv =====
// short queue of edge jobs between front and back
// depends on pmoes_pkg
module pmoes_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  pmoes_pkg::edge_job_t wr_job,
  output logic                 full,
  input  logic                 pop,
  output logic                 empty,
  output pmoes_pkg::edge_job_t rd_job
);

  pmoes_pkg::edge_job_t           entries [pmoes_pkg::QUEUE_DEPTH];
  logic [pmoes_pkg::QPTR_W-1:0]   wr_ptr;
  logic [pmoes_pkg::QPTR_W-1:0]   rd_ptr;
  logic [pmoes_pkg::QCNT_W-1:0]   fill;
  logic                           do_push;
  logic                           do_pop;

  assign full    = fill == pmoes_pkg::QCNT_W'(pmoes_pkg::QUEUE_DEPTH);
  assign empty   = fill == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

endmodule

// ===== design/pmoes_back.sv =====
// back end: reference registers, metric pipeline, running maximum and result register
// depends on pmoes_pkg
module pmoes_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [pmoes_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pmoes_pkg::REF_W-1:0]          cfg_data,
  input  logic                                 q_empty,
  input  pmoes_pkg::edge_job_t                 q_job,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [pmoes_pkg::EDGE_W-1:0]         edge_index,
  output logic                                 ref_zero_error,
  output logic                                 vertex_overflow
);

  logic signed [pmoes_pkg::REF_W-1:0]  ref_x, ref_y, ref_z, ref_w;
  logic [pmoes_pkg::PROD_W-1:0]        rr_sq [4];
  logic [pmoes_pkg::SQSUM_W-1:0]       rr;

  logic                                advance;
  logic                                s1_valid, s2_valid, s3_valid;
  logic [pmoes_pkg::EDGE_W-1:0]        s1_idx, s2_idx, s3_idx;
  logic                                s1_close, s2_close, s3_close;
  logic                                s1_ovf, s2_ovf, s3_ovf;
  logic [pmoes_pkg::PROD_W-1:0]        s1_sq [4];
  logic signed [pmoes_pkg::PROD_W-1:0] s1_pr [4];
  logic [pmoes_pkg::SQSUM_W-1:0]       s2_ee;
  logic signed [pmoes_pkg::DOT_W-1:0]  s2_re;
  logic [pmoes_pkg::METRIC_W-1:0]      s3_eerr;
  logic [pmoes_pkg::METRIC_W-1:0]      s3_re2;

  logic signed [2*pmoes_pkg::DOT_W-1:0] re2_full;
  logic [pmoes_pkg::METRIC_W-1:0]       metric;
  logic                                 better;
  logic [pmoes_pkg::EDGE_W-1:0]         new_edge;
  logic [pmoes_pkg::METRIC_W-1:0]       best_metric;
  logic [pmoes_pkg::EDGE_W-1:0]         best_edge;

  assign advance  = !(out_valid && out_stall);
  assign q_pop    = advance && !q_empty;
  assign re2_full = s2_re * s2_re;
  assign metric   = s3_eerr - s3_re2;
  assign better   = metric > best_metric;
  assign new_edge = better ? s3_idx : best_edge;

  // reference registers and r.r
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_x <= '0;
      ref_y <= '0;
      ref_z <= '0;
      ref_w <= '0;
      rr_sq <= '{default: '0};
      rr    <= '0;
    end else begin
      if (cfg_write) begin
        unique case (pmoes_pkg::cfg_reg_t'(cfg_index))
          pmoes_pkg::CFG_REF_X: ref_x <= cfg_data;
          pmoes_pkg::CFG_REF_Y: ref_y <= cfg_data;
          pmoes_pkg::CFG_REF_Z: ref_z <= cfg_data;
          pmoes_pkg::CFG_REF_W: ref_w <= cfg_data;
          default:              ref_x <= ref_x;
        endcase
      end
      rr_sq[0] <= ref_x * ref_x;
      rr_sq[1] <= ref_y * ref_y;
      rr_sq[2] <= ref_z * ref_z;
      rr_sq[3] <= ref_w * ref_w;
      rr <= pmoes_pkg::SQSUM_W'(rr_sq[0]) + pmoes_pkg::SQSUM_W'(rr_sq[1])
          + pmoes_pkg::SQSUM_W'(rr_sq[2]) + pmoes_pkg::SQSUM_W'(rr_sq[3]);
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      s2_valid        <= 1'b0;
      s3_valid        <= 1'b0;
      out_valid       <= 1'b0;
      best_metric     <= '0;
      best_edge       <= '0;
    end else if (advance) begin
      s1_valid  <= q_pop;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid && s3_close;
      if (s3_valid) begin
        if (s3_close) begin
          best_metric <= '0;
          best_edge   <= '0;
        end else if (better) begin
          best_metric <= metric;
          best_edge   <= s3_idx;
        end
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_sq[0] <= q_job.ex * q_job.ex;
      s1_sq[1] <= q_job.ey * q_job.ey;
      s1_sq[2] <= q_job.ez * q_job.ez;
      s1_sq[3] <= q_job.ew * q_job.ew;
      s1_pr[0] <= ref_x * q_job.ex;
      s1_pr[1] <= ref_y * q_job.ey;
      s1_pr[2] <= ref_z * q_job.ez;
      s1_pr[3] <= ref_w * q_job.ew;
      s1_idx   <= q_job.idx;
      s1_close <= q_job.close;
      s1_ovf   <= q_job.ovf;

      s2_ee <= pmoes_pkg::SQSUM_W'(s1_sq[0]) + pmoes_pkg::SQSUM_W'(s1_sq[1])
             + pmoes_pkg::SQSUM_W'(s1_sq[2]) + pmoes_pkg::SQSUM_W'(s1_sq[3]);
      s2_re <= pmoes_pkg::DOT_W'(s1_pr[0]) + pmoes_pkg::DOT_W'(s1_pr[1])
             + pmoes_pkg::DOT_W'(s1_pr[2]) + pmoes_pkg::DOT_W'(s1_pr[3]);
      s2_idx   <= s1_idx;
      s2_close <= s1_close;
      s2_ovf   <= s1_ovf;

      s3_eerr  <= s2_ee * rr;
      s3_re2   <= re2_full[pmoes_pkg::METRIC_W-1:0];
      s3_idx   <= s2_idx;
      s3_close <= s2_close;
      s3_ovf   <= s2_ovf;

      if (s3_valid && s3_close) begin
        edge_index      <= new_edge;
        ref_zero_error  <= rr == '0;
        vertex_overflow <= s3_ovf;
      end
    end
  end

endmodule

// ===== design/polygon_most_orthogonal_edge_select.sv =====
// polygon most-orthogonal edge selector, top level: front, job queue and back
// depends on pmoes_pkg, pmoes_front, pmoes_queue, pmoes_back and the macros header
// throughput: one vertex per cycle while the queue has room; a closing vertex after one or more
// vertices stalls the input while the front issues its own edge and then the wrap-around edge
// path from a closing vertex to the result: wrap-around issue (absent for a one-vertex polygon),
// queue, 3-stage metric pipe, result reg; reset zeroes state and the reference registers
`include "polygon_most_orthogonal_edge_select_macros.svh"

module polygon_most_orthogonal_edge_select (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [pmoes_pkg::COORD_W-1:0] vx,
  input  logic signed [pmoes_pkg::COORD_W-1:0] vy,
  input  logic signed [pmoes_pkg::COORD_W-1:0] vz,
  input  logic signed [pmoes_pkg::COORD_W-1:0] vw,
  input  logic                                last_vertex,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pmoes_pkg::EDGE_W-1:0]        edge_index,
  output logic                                ref_zero_error,
  output logic                                vertex_overflow,
  input  logic                                cfg_write,
  input  logic [pmoes_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pmoes_pkg::REF_W-1:0]         cfg_data
);

  pmoes_pkg::vertex_t   vtx;
  pmoes_pkg::q_wr_t     qw_ctl;
  pmoes_pkg::edge_job_t wr_job;
  pmoes_pkg::edge_job_t rd_job;
  logic                 q_full;
  logic                 q_empty;
  logic                 q_pop;

  assign vtx.x = vx;
  assign vtx.y = vy;
  assign vtx.z = vz;
  assign vtx.w = vw;

  pmoes_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .vtx         (vtx),
    .last_vertex (last_vertex),
    .qw_ctl      (qw_ctl),
    .q_full      (q_full),
    .job         (wr_job)
  );

  pmoes_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (qw_ctl.push),
    .wr_job (wr_job),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_job (rd_job)
  );

  pmoes_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_empty         (q_empty),
    .q_job           (rd_job),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .edge_index      (edge_index),
    .ref_zero_error  (ref_zero_error),
    .vertex_overflow (vertex_overflow)
  );

  `PMOES_ASSERT_SAME(a_full_stalls_input, clk, rst, q_full, in_stall)
  `PMOES_ASSERT_SAME(a_no_push_when_full, clk, rst, qw_ctl.push, !qw_ctl.full)
  `PMOES_ASSERT_SAME(a_no_pop_when_empty, clk, rst, q_pop, !q_empty)
  `PMOES_ASSERT_NEXT(a_stalled_result_holds, clk, rst, out_valid && out_stall, out_valid && $stable(edge_index) && $stable(ref_zero_error) && $stable(vertex_overflow))

endmodule

// ===== test/polygon_edge_choice_checker.sv =====
// checker for the polygon most-orthogonal edge selector: watches both channels and the
// register port, predicts the chosen edge of each closed polygon and compares results
// depends on pmoes_pkg
module polygon_edge_choice_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [pmoes_pkg::COORD_W-1:0]        vx,
  input  logic [pmoes_pkg::COORD_W-1:0]        vy,
  input  logic [pmoes_pkg::COORD_W-1:0]        vz,
  input  logic [pmoes_pkg::COORD_W-1:0]        vw,
  input  logic                                 last_vertex,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic [pmoes_pkg::EDGE_W-1:0]         edge_index,
  input  logic                                 ref_zero_error,
  input  logic                                 vertex_overflow,
  input  logic                                 cfg_write,
  input  logic [pmoes_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pmoes_pkg::REF_W-1:0]          cfg_data,
  output int                                   pending,
  output int                                   failures,
  output int                                   polygons_closed
);

  typedef struct packed {
    logic [pmoes_pkg::EDGE_W-1:0] edge_idx;
    logic                         zero_ref;
    logic                         overflow;
  } edge_choice_t;

  edge_choice_t choices_due[$];

  logic signed [pmoes_pkg::REF_W-1:0] ref_q[4];
  pmoes_pkg::vertex_t                 first_pt;
  pmoes_pkg::vertex_t                 prev_pt;
  int                                 vcount;
  logic                               extra_seen;
  logic [63:0]                        best_metric;
  logic [pmoes_pkg::EDGE_W-1:0]       best_idx;
  int                                 mism;
  int                                 closed;

  function automatic logic [63:0] ref_norm2();
    logic signed [63:0] r;
    logic signed [63:0] acc;
    int k;
    acc = 0;
    for (k = 0; k < 4; k++) begin
      r = ref_q[k];
      acc += r * r;
    end
    return acc;
  endfunction

  // (e.e)(r.r) - (r.e)^2 for the edge from a to b
  function automatic logic [63:0] orth_metric(input pmoes_pkg::vertex_t a,
                                              input pmoes_pkg::vertex_t b);
    logic signed [63:0] d[4];
    logic signed [63:0] r;
    logic signed [63:0] ee;
    logic signed [63:0] re;
    int k;
    d[0] = $signed(b.x) - $signed(a.x);
    d[1] = $signed(b.y) - $signed(a.y);
    d[2] = $signed(b.z) - $signed(a.z);
    d[3] = $signed(b.w) - $signed(a.w);
    ee = 0;
    re = 0;
    for (k = 0; k < 4; k++) begin
      r = ref_q[k];
      ee += d[k] * d[k];
      re += r * d[k];
    end
    return ee * $signed(ref_norm2()) - re * re;
  endfunction

  task automatic rank_edge(input pmoes_pkg::vertex_t a, input pmoes_pkg::vertex_t b,
                           input int idx);
    logic [63:0] m;
    m = orth_metric(a, b);
    if (m > best_metric) begin
      best_metric = m;
      best_idx = idx[pmoes_pkg::EDGE_W-1:0];
    end
  endtask

  task automatic clear_polygon();
    first_pt = '0;
    prev_pt = '0;
    vcount = 0;
    extra_seen = 1'b0;
    best_metric = '0;
    best_idx = '0;
  endtask

  task automatic take_vertex(input pmoes_pkg::vertex_t cur, input logic closing);
    edge_choice_t c;
    if (vcount >= pmoes_pkg::MAX_VERTICES) begin
      extra_seen = 1'b1;
    end else begin
      if (vcount == 0) first_pt = cur;
      else rank_edge(prev_pt, cur, vcount - 1);
      prev_pt = cur;
      vcount++;
    end
    if (closing) begin
      rank_edge(prev_pt, first_pt, vcount - 1);
      c.edge_idx = best_idx;
      c.zero_ref = (ref_norm2() == 0);
      c.overflow = extra_seen;
      choices_due = {choices_due, c};
      clear_polygon();
    end
  endtask

  always @(posedge clk) begin
    edge_choice_t got;
    edge_choice_t want;
    if (rst) begin
      for (int k = 0; k < 4; k++) ref_q[k] = '0;
      clear_polygon();
      choices_due.delete();
      mism = 0;
      closed = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {edge_index, ref_zero_error, vertex_overflow};
        if (choices_due.size() == 0) begin
          mism++;
          if (mism <= 10)
            $display("unexpected result transaction: edge %0d zero_ref %0b overflow %0b",
                     got.edge_idx, got.zero_ref, got.overflow);
        end else begin
          want = choices_due.pop_front();
          closed++;
          if (got !== want) begin
            mism++;
            if (mism <= 10)
              $display("mismatch on polygon %0d: expected edge %0d zero_ref %0b overflow %0b",
                       closed, want.edge_idx, want.zero_ref, want.overflow,
                       ", got edge %0d zero_ref %0b overflow %0b",
                       got.edge_idx, got.zero_ref, got.overflow);
          end
        end
      end
      if (cfg_write) begin
        case (pmoes_pkg::cfg_reg_t'(cfg_index))
          pmoes_pkg::CFG_REF_X: ref_q[0] = cfg_data;
          pmoes_pkg::CFG_REF_Y: ref_q[1] = cfg_data;
          pmoes_pkg::CFG_REF_Z: ref_q[2] = cfg_data;
          pmoes_pkg::CFG_REF_W: ref_q[3] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        take_vertex({vx, vy, vz, vw}, last_vertex);
    end
    pending <= choices_due.size();
    failures <= mism;
    polygons_closed <= closed;
  end

endmodule

// ===== test/tb_polygon_most_orthogonal_edge_select.sv =====
// testbench top for the polygon most-orthogonal edge selector: drives directed and random
// polygons under several reference settings and pacing modes, then gives the verdict
// depends on pmoes_pkg, polygon_most_orthogonal_edge_select and polygon_edge_choice_checker
module tb_polygon_most_orthogonal_edge_select;

  localparam int LIMIT = 400000;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [pmoes_pkg::COORD_W-1:0]   vx = '0;
  logic [pmoes_pkg::COORD_W-1:0]   vy = '0;
  logic [pmoes_pkg::COORD_W-1:0]   vz = '0;
  logic [pmoes_pkg::COORD_W-1:0]   vw = '0;
  logic                            last_vertex = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [pmoes_pkg::EDGE_W-1:0]    edge_index;
  logic                            ref_zero_error;
  logic                            vertex_overflow;
  logic                            cfg_write = 1'b0;
  logic [pmoes_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pmoes_pkg::REF_W-1:0]     cfg_data = '0;

  int pending;
  int failures;
  int polygons_closed;
  int cycle_count = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int vertices_sent = 0;
  int settings_used = 0;

  polygon_most_orthogonal_edge_select uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .vx(vx), .vy(vy), .vz(vz), .vw(vw), .last_vertex(last_vertex),
    .out_valid(out_valid), .out_stall(out_stall),
    .edge_index(edge_index), .ref_zero_error(ref_zero_error),
    .vertex_overflow(vertex_overflow),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  polygon_edge_choice_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .vx(vx), .vy(vy), .vz(vz), .vw(vw), .last_vertex(last_vertex),
    .out_valid(out_valid), .out_stall(out_stall),
    .edge_index(edge_index), .ref_zero_error(ref_zero_error),
    .vertex_overflow(vertex_overflow),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .failures(failures), .polygons_closed(polygons_closed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("tb_polygon_most_orthogonal_edge_select failed");
      $finish;
    end
  end

  function automatic logic [pmoes_pkg::COORD_W-1:0] pick_coord(input int style);
    case (style)
      0: begin
        case ($urandom_range(2))
          0: return 14'h1fff;
          1: return 14'h2000;
          default: return '0;
        endcase
      end
      1: return pmoes_pkg::COORD_W'($urandom_range(0, 31) - 16);
      default: return pmoes_pkg::COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic [pmoes_pkg::REF_W-1:0] pick_ref();
    case ($urandom_range(7))
      0: return '0;
      1: return 15'h4000;
      2: return 15'h3fff;
      3: return 15'h4001;
      4, 5: return pmoes_pkg::REF_W'($urandom_range(0, 15) - 8);
      default: return pmoes_pkg::REF_W'($urandom);
    endcase
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 1;
    if (r < 14) return 2;
    if (r < 90) return $urandom_range(3, 8);
    return $urandom_range(9, 24);
  endfunction

  task automatic put_vertex(input logic [pmoes_pkg::COORD_W-1:0] x, y, z, w,
                            input logic closing);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    vx <= x;
    vy <= y;
    vz <= z;
    vw <= w;
    last_vertex <= closing;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    vertices_sent++;
  endtask

  // let every open polygon close and the pipeline empty before touching registers
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_reference(input logic [pmoes_pkg::REF_W-1:0] x, y, z, w);
    cfg_write <= 1'b1;
    cfg_index <= pmoes_pkg::CFG_REF_X;
    cfg_data <= x;
    @(posedge clk);
    cfg_index <= pmoes_pkg::CFG_REF_Y;
    cfg_data <= y;
    @(posedge clk);
    cfg_index <= pmoes_pkg::CFG_REF_Z;
    cfg_data <= z;
    @(posedge clk);
    cfg_index <= pmoes_pkg::CFG_REF_W;
    cfg_data <= w;
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  task automatic send_polygon(input int nverts);
    int style;
    int pick;
    int k;
    int j;
    int t;
    logic ok;
    logic [pmoes_pkg::COORD_W-1:0] pt[4];
    logic [pmoes_pkg::COORD_W-1:0] prev[4];
    logic [pmoes_pkg::COORD_W-1:0] stride[4];
    style = $urandom_range(9);
    for (j = 0; j < 4; j++) begin
      prev[j] = '0;
      stride[j] = '0;
    end
    for (k = 0; k < nverts; k++) begin
      pick = $urandom_range(9);
      if (k > 0 && pick == 0) begin
        pt = prev;
      end else if (k > 1 && pick == 1) begin
        // same edge vector again, gives a tie
        ok = 1'b1;
        for (j = 0; j < 4; j++) begin
          t = $signed(prev[j]) + $signed(stride[j]);
          if (t > 8191 || t < -8192) ok = 1'b0;
          pt[j] = t[pmoes_pkg::COORD_W-1:0];
        end
        if (!ok)
          for (j = 0; j < 4; j++) pt[j] = pick_coord(style);
      end else begin
        for (j = 0; j < 4; j++) pt[j] = pick_coord(style);
      end
      for (j = 0; j < 4; j++) begin
        stride[j] = pt[j] - prev[j];
        prev[j] = pt[j];
      end
      put_vertex(pt[0], pt[1], pt[2], pt[3], k == nverts - 1);
    end
  endtask

  task automatic run_phase(input int gap_pct, input int stall_pct, input int big_size);
    int done;
    int n;
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    done = 0;
    while (done < 80) begin
      wait_quiet();
      if ($urandom_range(7) == 0) set_reference('0, '0, '0, '0);
      else set_reference(pick_ref(), pick_ref(), pick_ref(), pick_ref());
      repeat ($urandom_range(3, 8)) begin
        n = pick_size();
        send_polygon(n);
        done += n;
      end
    end
    if (big_size > 0) begin
      wait_quiet();
      set_reference(pmoes_pkg::REF_W'($urandom), pmoes_pkg::REF_W'($urandom), 15'h0001,
                    pick_ref());
      send_polygon(big_size);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_gap_pct = 23;
    recv_stall_pct = 83;

    // reference still at reset value
    put_vertex(14'h0000, 14'h0000, 14'h0000, 14'h0000, 1'b0);
    put_vertex(14'h1fff, 14'h1fff, 14'h1fff, 14'h1fff, 1'b0);
    put_vertex(14'h2000, 14'h2000, 14'h2000, 14'h2000, 1'b1);

    wait_quiet();
    set_reference(15'h3fff, 15'h4000, 15'h0001, 15'h0000);
    put_vertex(14'h1fff, 14'h2000, 14'h0000, 14'h0001, 1'b1);

    // largest products: extreme coordinates against the most negative reference
    wait_quiet();
    set_reference(15'h4000, 15'h4000, 15'h4000, 15'h4000);
    put_vertex(14'h2000, 14'h1fff, 14'h2000, 14'h1fff, 1'b0);
    put_vertex(14'h1fff, 14'h2000, 14'h1fff, 14'h2000, 1'b1);

    // zero-length edges only
    put_vertex(14'h0005, 14'h0005, 14'h0005, 14'h0005, 1'b0);
    put_vertex(14'h0005, 14'h0005, 14'h0005, 14'h0005, 1'b0);
    put_vertex(14'h0005, 14'h0005, 14'h0005, 14'h0005, 1'b1);

    // square of equal edges, ties keep edge 0
    wait_quiet();
    set_reference(15'h0000, 15'h0000, 15'h0000, 15'h0001);
    put_vertex(14'd0, 14'd0, 14'd0, 14'd0, 1'b0);
    put_vertex(14'd100, 14'd0, 14'd0, 14'd0, 1'b0);
    put_vertex(14'd100, 14'd100, 14'd0, 14'd0, 1'b0);
    put_vertex(14'd0, 14'd100, 14'd0, 14'd0, 1'b1);

    // repeated vertices with a late winner
    put_vertex(14'd0, 14'd0, 14'd0, 14'd0, 1'b0);
    put_vertex(14'd0, 14'd0, 14'd0, 14'd0, 1'b0);
    put_vertex(14'd3, 14'd0, 14'd0, 14'd0, 1'b0);
    put_vertex(14'd3, 14'd0, 14'd0, 14'd0, 1'b0);
    put_vertex(14'd3, 14'd7, 14'd0, 14'd0, 1'b1);

    run_phase(23, 83, 0);
    run_phase(83, 23, pmoes_pkg::MAX_VERTICES + $urandom_range(1, 3));
    run_phase(0, 0, 0);

    wait_quiet();
    $display("covered %0d polygons from %0d vertices under %0d reference settings",
             polygons_closed, vertices_sent, settings_used);
    $display("pacing: slow receiver, slow sender, then back to back; one overflowing polygon");
    if (failures == 0 && pending == 0) begin
      $display("tb_polygon_most_orthogonal_edge_select passed");
    end else begin
      $display("tb_polygon_most_orthogonal_edge_select failed");
    end
    $finish;
  end

endmodule

// ===== polygon_most_orthogonal_edge_select.f =====
+incdir+design
design/pmoes_pkg.sv
design/pmoes_front.sv
design/pmoes_queue.sv
design/pmoes_back.sv
design/polygon_most_orthogonal_edge_select.sv
test/polygon_edge_choice_checker.sv
test/tb_polygon_most_orthogonal_edge_select.sv
